>>> rtl/erf_pkg.sv
// ----------------------------------------------------------------------------
// erf_pkg
// Shared types, widths and register codes of the echo range spike filter.
// ----------------------------------------------------------------------------
package erf_pkg;

  localparam int CounterBitsDef = 16;
  localparam int CountW         = 16;
  localparam int ScaleW         = 24;
  localparam int DistW          = 16;
  localparam int ScaleFrac      = 16;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 24;

  localparam logic [CountW-1:0] PeriodReset = 16'd29999;
  localparam logic [ScaleW-1:0] ScaleReset  = 24'd17825;
  localparam logic [DistW-1:0]  LimitReset  = 16'd800;
  localparam logic [DistW-1:0]  DistMax     = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_RISE = 1'b0,
    KIND_FALL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [CountW-1:0] period_last_count;
    logic [ScaleW-1:0] ticks_scale;
    logic [DistW-1:0]  jump_limit;
  } cfg_t;

endpackage

>>> rtl/echo_range_spike_filter.sv
// ----------------------------------------------------------------------------
// echo_range_spike_filter
// Echo edge timing to distance with a spike-rejecting jump filter.
// ----------------------------------------------------------------------------
// Takes one edge word per cycle while s_tready is high. A rising edge stores
// its count and gives no result; a falling edge gives one result word: input
// register, pulse length and scaling multiply into the raw distance register,
// then the jump filter into the output register. The single multiplier stage
// sets the rate of one word per cycle; a waiting result lets one more falling
// edge fill the raw distance register, after which the input stalls.
module echo_range_spike_filter import erf_pkg::*; #(
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CountW-1:0]   s_tdata,    // [15:0] capture_count
  input  logic                s_tuser,    // [0] kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [2*DistW-1:0]  m_tdata,    // [15:0] distance, [31:16] raw_distance
  output logic                m_tuser,    // [0] spike_held
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t              cfg;
  logic              v1;
  kind_t             in_kind;
  logic [CountW-1:0] in_count;
  logic              v2;
  logic              o_free;
  logic              v2_go;
  logic              s2_free;
  logic              s1_go;
  logic [DistW-1:0]  raw_q;
  logic [DistW-1:0]  distance;
  logic [DistW-1:0]  raw_distance;
  logic              spike_held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_last_count <= PeriodReset;
      cfg.ticks_scale       <= ScaleReset;
      cfg.jump_limit        <= LimitReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD: cfg.period_last_count <= cfg_data[CountW-1:0];
        CFG_SCALE:  cfg.ticks_scale       <= cfg_data[ScaleW-1:0];
        CFG_LIMIT:  cfg.jump_limit        <= cfg_data[DistW-1:0];
        default: ;
      endcase
    end
  end

  assign o_free   = !m_tvalid || m_tready;
  assign v2_go    = v2 && o_free;
  assign s2_free  = !v2 || v2_go;
  assign s1_go    = v1 && (in_kind == KIND_RISE || s2_free);
  assign s_tready = !v1 || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        v1 <= 1'b1;
      end else if (s1_go) begin
        v1 <= 1'b0;
      end
      if (s1_go && in_kind == KIND_FALL) begin
        v2 <= 1'b1;
      end else if (v2_go) begin
        v2 <= 1'b0;
      end
      if (v2_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= kind_t'(s_tuser);
      in_count <= s_tdata;
    end
  end

  erf_range #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_range (
    .clk          (clk),
    .rst          (rst),
    .load_start   (s1_go && in_kind == KIND_RISE),
    .load_raw     (s1_go && in_kind == KIND_FALL),
    .capture_count(in_count),
    .cfg          (cfg),
    .raw_distance (raw_q)
  );

  erf_filter u_filter (
    .clk         (clk),
    .rst         (rst),
    .load        (v2_go),
    .raw_in      (raw_q),
    .jump_limit  (cfg.jump_limit),
    .distance    (distance),
    .raw_distance(raw_distance),
    .spike_held  (spike_held)
  );

  assign m_tdata = {raw_distance, distance};
  assign m_tuser = spike_held;

`ifndef SYNTHESIS
  a_held_differs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[DistW-1:0] != m_tdata[2*DistW-1:DistW]))
    else $error("held word carries its own raw distance");

  a_pass_equal: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[DistW-1:0] == m_tdata[2*DistW-1:DistW]))
    else $error("accepted word differs from raw distance");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_tready)
    else $error("input stalled with empty input register");

  a_rise_no_word: assert property (@(posedge clk) disable iff (rst)
    (s1_go && in_kind == KIND_RISE && !v2) |=> !v2)
    else $error("rising edge produced a word");
`endif

endmodule

>>> rtl/erf_range.sv
// ----------------------------------------------------------------------------
// erf_range
// Pulse start capture, wrapped pulse length and scaling to a saturated
// distance, registered.
// ----------------------------------------------------------------------------
module erf_range import erf_pkg::*; #(
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_start,
  input  logic              load_raw,
  input  logic [CountW-1:0] capture_count,
  input  cfg_t              cfg,
  output logic [DistW-1:0]  raw_distance
);

  localparam int CntW  = (COUNTER_BITS < CountW) ? COUNTER_BITS : CountW;
  localparam int ProdW = COUNTER_BITS + ScaleW;

  logic [CountW-1:0]       start_count;
  logic [COUNTER_BITS-1:0] s_cnt;
  logic [COUNTER_BITS-1:0] e_cnt;
  logic [COUNTER_BITS-1:0] p_cnt;
  logic [COUNTER_BITS-1:0] delta;
  logic [ProdW-1:0]        prod;
  logic [DistW-1:0]        raw_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count <= '0;
    end else if (load_start) begin
      start_count <= capture_count;
    end
  end

  always_comb begin
    s_cnt = COUNTER_BITS'(start_count[CntW-1:0]);
    e_cnt = COUNTER_BITS'(capture_count[CntW-1:0]);
    p_cnt = COUNTER_BITS'(cfg.period_last_count[CntW-1:0]);
    if (e_cnt >= s_cnt) begin
      delta = e_cnt - s_cnt;
    end else begin
      delta = p_cnt - s_cnt + e_cnt + COUNTER_BITS'(1);
    end
    prod = ProdW'(delta) * ProdW'(cfg.ticks_scale);
    if ((prod >> (ScaleFrac + DistW)) != '0) begin
      raw_next = DistMax;
    end else begin
      raw_next = prod[ScaleFrac +: DistW];
    end
  end

  always_ff @(posedge clk) begin
    if (load_raw) begin
      raw_distance <= raw_next;
    end
  end

endmodule

>>> rtl/erf_filter.sv
// ----------------------------------------------------------------------------
// erf_filter
// Jump filter on the distance readings and the registered result word.
// ----------------------------------------------------------------------------
module erf_filter import erf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [DistW-1:0] raw_in,
  input  logic [DistW-1:0] jump_limit,
  output logic [DistW-1:0] distance,
  output logic [DistW-1:0] raw_distance,
  output logic             spike_held
);

  logic [DistW-1:0] held_distance;
  logic [DistW-1:0] held_distance_next;
  logic             have_reading;
  logic             spike_seen;
  logic             spike_seen_next;
  logic             held_next;
  logic [DistW-1:0] diff;

  always_comb begin
    diff               = (raw_in > held_distance) ? raw_in - held_distance
                                                  : held_distance - raw_in;
    held_distance_next = raw_in;
    spike_seen_next    = 1'b0;
    held_next          = 1'b0;
    if (have_reading && diff > jump_limit && !spike_seen) begin
      held_distance_next = held_distance;
      spike_seen_next    = 1'b1;
      held_next          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_distance <= '0;
      have_reading  <= 1'b0;
      spike_seen    <= 1'b0;
    end else if (load) begin
      held_distance <= held_distance_next;
      have_reading  <= 1'b1;
      spike_seen    <= spike_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      distance     <= held_distance_next;
      raw_distance <= raw_in;
      spike_held   <= held_next;
    end
  end

endmodule
